### rtl/bfra_pkg.sv
package bfra_pkg;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 31;
  localparam int SIZE_W   = 31;
  localparam int ST_W     = 2;
  localparam int BCOUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [ADDR_W-1:0]   found_address;
    logic [SIZE_W-1:0]   found_size;
    logic [BCOUNT_W-1:0] block_count;
  } out_word_t;

endpackage

### rtl/best_fit_ring_allocator_top.sv
// Best-fit free-block allocator over a compacted ring of (address, size) blocks.
// A word is taken when start is high and busy is low; exactly one result word
// follows, shown on out_word for one cycle with out_strobe high, and the
// receiver cannot stall it. Insert, a bad operation, a full insert, an
// allocate on an empty ring and an out-of-range read are answered in the
// cycle after the word is taken and leave busy low. A read in range passes
// through the registered memory read and the read-wait state. An allocate
// walks every block once through one shared compare unit fed by the single
// memory read port. An exact fit on any block but the last then closes the
// gap by moving each later block down one slot, one per cycle over the same
// read port and the write port. No clearing pass runs after reset.
module best_fit_ring_allocator_top
  import bfra_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RDWAIT
  } state_t;

  // block storage, kept compacted in slots 0 .. count-1
  logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
  logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_addr_q;
  logic [SIZE_W-1:0] rd_size_q;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [SIZE_W-1:0] wr_size;
  logic [IDX_W-1:0]  rd_idx;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [ADDR_W-1:0] best_addr_r, best_addr_nxt;
  logic [SIZE_W-1:0] amt_r, amt_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              accept;
  logic [CNT_W:0]    ptr_inc;
  logic [CNT_W:0]    rd_sum;
  logic [CNT_W-1:0]  best_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic              fits;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  assign ptr_inc  = (CNT_W+1)'(ptr_r) + (CNT_W+1)'(1);
  assign rd_sum   = (CNT_W+1)'(rover_r) + (CNT_W+1)'(in_word.amount[CNT_W-1:0]);
  assign best_inc = CNT_W'(best_idx_r) + CNT_W'(1);
  assign cnt_dec  = count_r - CNT_W'(1);

  // shared compare unit: candidate beats the best so far
  assign fits = pend_v_r && (rd_size_q >= amt_r) &&
                (!found_r || (rd_size_q < best_size_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_addr;
      size_mem[wr_idx] <= wr_size;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= addr_mem[rd_idx];
    rd_size_q <= size_mem[rd_idx];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rover_nxt      = rover_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    pend_v_nxt     = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_addr_nxt  = best_addr_r;
    amt_nxt        = amt_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    wr_en          = 1'b0;
    wr_idx         = pend_idx_r;
    wr_addr        = rd_addr_q;
    wr_size        = rd_size_q;
    rd_idx         = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          amt_nxt = in_word.amount;
          case (in_word.operation)
            OP_INSERT: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = '{ST_FULL, '0, '0, BCOUNT_W'(count_r)};
              end else begin
                // append at the end and restart the rover
                wr_en          = 1'b1;
                wr_idx         = count_r[IDX_W-1:0];
                wr_addr        = in_word.block_address;
                wr_size        = in_word.amount;
                count_nxt      = count_r + CNT_W'(1);
                rover_nxt      = '0;
                out_strobe_nxt = 1'b1;
                out_word_nxt   = '{ST_OK, in_word.block_address, in_word.amount,
                                   BCOUNT_W'(count_nxt)};
              end
            end
            OP_ALLOC: begin
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = '{ST_EMPTY, '0, '0, BCOUNT_W'(count_r)};
              end else begin
                ptr_nxt   = rover_r;
                left_nxt  = count_r;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            OP_READ: begin
              if (in_word.amount >= SIZE_W'(count_r)) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = '{ST_EMPTY, '0, '0, BCOUNT_W'(count_r)};
              end else begin
                // rover + k stays below twice the count: one subtract wraps it
                if (rd_sum >= (CNT_W+1)'(count_r)) begin
                  rd_idx = IDX_W'(rd_sum - (CNT_W+1)'(count_r));
                end else begin
                  rd_idx = IDX_W'(rd_sum);
                end
                state_nxt = S_RDWAIT;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_word_nxt   = '{ST_EMPTY, '0, '0, BCOUNT_W'(count_r)};
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, judge the word read the cycle before
        if (left_r != '0) begin
          rd_idx       = ptr_r;
          ptr_nxt      = (ptr_inc == (CNT_W+1)'(count_r)) ? '0 : IDX_W'(ptr_inc);
          left_nxt     = left_r - CNT_W'(1);
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = ptr_r;
        end else begin
          state_nxt = S_DECIDE;
        end
        if (fits) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = pend_idx_r;
          best_size_nxt = rd_size_q;
          best_addr_nxt = rd_addr_q;
        end
      end

      S_DECIDE: begin
        if (!found_r) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{ST_NOFIT, '0, '0, BCOUNT_W'(count_r)};
          state_nxt      = S_IDLE;
        end else if (best_size_r == amt_r) begin
          if (best_inc == count_r) begin
            count_nxt      = cnt_dec;
            rover_nxt      = '0;
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '{ST_OK, best_addr_r, '0, BCOUNT_W'(cnt_dec)};
            state_nxt      = S_IDLE;
          end else begin
            // close the gap: move every later block down one slot
            ptr_nxt   = IDX_W'(best_inc);
            left_nxt  = cnt_dec - CNT_W'(best_idx_r);
            state_nxt = S_SHIFT;
          end
        end else begin
          wr_en          = 1'b1;
          wr_idx         = best_idx_r;
          wr_addr        = best_addr_r;
          wr_size        = best_size_r - amt_r;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{ST_OK, best_addr_r, wr_size, BCOUNT_W'(count_r)};
          state_nxt      = S_IDLE;
        end
      end

      S_SHIFT: begin
        if (left_r != '0) begin
          rd_idx       = ptr_r;
          ptr_nxt      = IDX_W'(ptr_inc);
          left_nxt     = left_r - CNT_W'(1);
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = ptr_r - IDX_W'(1);
        end
        if (pend_v_r) begin
          wr_en  = 1'b1;
          wr_idx = pend_idx_r;
        end
        if (left_r == '0) begin
          // the removed slot was below the last one, so its successor now
          // sits in it: hold the rover on that slot
          count_nxt      = cnt_dec;
          rover_nxt      = (CNT_W'(best_idx_r) >= cnt_dec) ? '0 : best_idx_r;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{ST_OK, best_addr_r, '0, BCOUNT_W'(cnt_dec)};
          state_nxt      = S_IDLE;
        end
      end

      S_RDWAIT: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt   = '{ST_OK, rd_addr_q, rd_size_q, BCOUNT_W'(count_r)};
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rover_r      <= '0;
      left_r       <= '0;
      pend_v_r     <= 1'b0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rover_r      <= rover_nxt;
      left_r       <= left_nxt;
      pend_v_r     <= pend_v_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    ptr_r       <= ptr_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    best_addr_r <= best_addr_nxt;
    amt_r       <= amt_nxt;
    out_word_r  <= out_word_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("block count exceeds table depth");

  a_rover_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(rover_r) < count_r) || (rover_r == '0))
    else $error("rover points outside the ring");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result shown while an operation is in flight");

  a_quick_ops_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.operation != OP_ALLOC && in_word.operation != OP_READ)
    |=> (out_strobe && !busy))
    else $error("single-cycle operation gave no result");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == ST_FULL) |-> (count_r == CNT_W'(TABLE_DEPTH)))
    else $error("table full flagged with free slots left");

endmodule
